FILE: design/assert_macros.svh
// assertion helper macros used by the checker file hsfc_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// types and constants for the half/single float converter
// ----------------------------------------------------------------------------
`default_nettype none
package hsfc_pkg;
  localparam logic OP_H2S = 1'b0;
  localparam logic OP_S2H = 1'b1;
  localparam int unsigned PIPE_DEPTH = 3;

  localparam logic [14:0] HALF_INF  = 15'h7c00;
  localparam logic [14:0] HALF_QNAN = 15'h7e00;

  typedef struct packed {
    logic        opcode;
    logic [15:0] half_in;
    logic [31:0] single_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] single_out;
    logic [15:0] half_out;
  } out_item_t;

  // stage 1 -> stage 2 decode of both directions
  typedef struct packed {
    logic        opcode;
    logic        sign;
    // half to single
    logic        h_zero;
    logic        h_sub;
    logic        h_special;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [3:0]  h_lz;
    // single to half
    logic        s_nan;
    logic        s_inf;
    logic        s_zero;
    logic        s_sub;
    logic        s_norm;
    logic [4:0]  s_sh;
    logic [4:0]  s_exp;
    logic [22:0] s_man;
  } dec_t;
endpackage
`default_nettype wire

FILE: design/hsfc_decode.sv
// ----------------------------------------------------------------------------
// hsfc_decode
// stage 1: field split, class detection, leading-zero count, shift amount
// ----------------------------------------------------------------------------
`default_nettype none
module hsfc_decode (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  hsfc_pkg::in_item_t  in_item,
  output logic                dec_valid,
  output hsfc_pkg::dec_t      dec
);
  hsfc_pkg::dec_t dec_next;
  logic [7:0] s_e;
  logic [9:0] hm;

  always_comb begin
    dec_next = '0;
    dec_next.opcode = in_item.opcode;
    hm = in_item.half_in[9:0];
    s_e = in_item.single_in[30:23];
    dec_next.h_exp = in_item.half_in[14:10];
    dec_next.h_man = hm;
    dec_next.h_zero = (dec_next.h_exp == 5'd0) && (hm == 10'd0);
    dec_next.h_sub = (dec_next.h_exp == 5'd0) && (hm != 10'd0);
    dec_next.h_special = (dec_next.h_exp == 5'd31);
    // shift that brings the leading one just above the 10-bit field
    dec_next.h_lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) dec_next.h_lz = 4'(10 - i);
    end
    dec_next.s_man = in_item.single_in[22:0];
    dec_next.s_nan = (s_e == 8'hff) && (dec_next.s_man != 23'd0);
    dec_next.s_inf = (s_e == 8'hff && dec_next.s_man == 23'd0) ||
                     (s_e != 8'hff && s_e >= 8'd143);
    dec_next.s_norm = (s_e >= 8'd113) && (s_e <= 8'd142);
    dec_next.s_sub = (s_e >= 8'd102) && (s_e <= 8'd112);
    dec_next.s_zero = (s_e < 8'd102);
    dec_next.s_exp = 5'(s_e - 8'd112);
    // shift 14 - hexp = 126 - e, range 14..24
    dec_next.s_sh = 5'(8'd126 - s_e);
    dec_next.sign = in_item.opcode ? in_item.single_in[31] : in_item.half_in[15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_valid;
    end
    dec <= dec_next;
  end
endmodule
`default_nettype wire

FILE: design/hsfc_assemble.sv
// ----------------------------------------------------------------------------
// hsfc_assemble
// stages 2 and 3: shifting and round-bit selection, then rounding and result packing
// ----------------------------------------------------------------------------
`default_nettype none
module hsfc_assemble (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 dec_valid,
  input  hsfc_pkg::dec_t      dec,
  output logic                out_valid,
  output hsfc_pkg::out_item_t out_item
);
  // stage 2 results
  logic        s2_valid;
  logic        s2_opcode;
  logic [31:0] s2_single;
  logic [14:0] s2_mag;
  logic        s2_sign;
  logic        s2_round;

  logic [31:0] single_next;
  logic [14:0] mag_next;
  logic        round_next;
  logic [10:0] hsub_norm;
  logic [23:0] norm;
  logic [7:0]  e32;
  logic [14:0] rounded;

  always_comb begin
    single_next = '0;
    mag_next = '0;
    round_next = 1'b0;
    hsub_norm = 11'({1'b0, dec.h_man} << dec.h_lz);
    norm = {1'b1, dec.s_man};
    e32 = 8'd0;
    if (dec.h_zero) begin
      single_next = {dec.sign, 31'd0};
    end else if (dec.h_sub) begin
      e32 = 8'(8'd113 - {4'd0, dec.h_lz});
      single_next = {dec.sign, e32, hsub_norm[9:0], 13'd0};
    end else if (dec.h_special) begin
      single_next = {dec.sign, 8'hff, dec.h_man, 13'd0};
    end else begin
      e32 = 8'({3'd0, dec.h_exp} + 8'd112);
      single_next = {dec.sign, e32, dec.h_man, 13'd0};
    end
    if (dec.s_nan) begin
      mag_next = hsfc_pkg::HALF_QNAN;
    end else if (dec.s_inf) begin
      mag_next = hsfc_pkg::HALF_INF;
    end else if (dec.s_zero) begin
      mag_next = '0;
    end else if (dec.s_sub) begin
      mag_next = 15'(norm >> dec.s_sh);
      round_next = norm[dec.s_sh - 5'd1];
    end else begin
      mag_next = {dec.s_exp, dec.s_man[22:13]};
      round_next = dec.s_man[12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= dec_valid;
    end
    s2_opcode <= dec.opcode;
    s2_single <= single_next;
    s2_mag <= mag_next;
    s2_sign <= dec.sign;
    s2_round <= round_next;
  end

  // carry into exponent is natural; reaching 0x7c00 is infinity
  assign rounded = 15'(s2_mag + {14'd0, s2_round});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
    if (s2_opcode == hsfc_pkg::OP_H2S) begin
      out_item <= '{single_out: s2_single, half_out: 16'd0};
    end else begin
      out_item <= '{single_out: 32'd0, half_out: {s2_sign, rounded}};
    end
  end
endmodule
`default_nettype wire

FILE: design/half_single_float_convert_top.sv
// ----------------------------------------------------------------------------
// half_single_float_convert_top
// binary16 <-> binary32 converter, three register stages
// ----------------------------------------------------------------------------
// channel  | signals                   | transfer
// command  | start, busy, in_data      | start && !busy
// result   | done, out_data            | done (one cycle)
//
// one item per cycle; start passes through the decode, stage 2 and output registers to done
// busy is always low: the pipeline never stalls
// rst clears the stage valid bits only
// ----------------------------------------------------------------------------
`default_nettype none
module half_single_float_convert_top (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  hsfc_pkg::in_item_t  in_data,
  output logic                done,
  output hsfc_pkg::out_item_t out_data
);
  logic           dec_valid;
  hsfc_pkg::dec_t dec;

  assign busy = 1'b0;

  hsfc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_item   (in_data),
    .dec_valid (dec_valid),
    .dec       (dec)
  );

  hsfc_assemble u_assemble (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec       (dec),
    .out_valid (done),
    .out_item  (out_data)
  );
endmodule
`default_nettype wire

FILE: design/hsfc_checker.sv
// ----------------------------------------------------------------------------
// hsfc_checker
// port-level checks on the converter
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hsfc_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 start,
  input wire                 busy,
  input hsfc_pkg::in_item_t  in_data,
  input wire                 done,
  input hsfc_pkg::out_item_t out_data
);
  logic accepted;
  logic h2s_accepted;
  logic one_field_zero;

  assign accepted = start && !busy;
  assign h2s_accepted = accepted && (in_data.opcode == hsfc_pkg::OP_H2S);
  assign one_field_zero = (out_data.single_out == 32'd0) || (out_data.half_out == 16'd0);

  `ASSERT_NEXT(a_done_follows, clk, rst, accepted, ##2 done)
  `ASSERT_IMPL(a_done_has_start, clk, rst, done, $past(accepted, 3))
  `ASSERT_IMPL(a_one_field, clk, rst, done, one_field_zero)
  `ASSERT_NEXT(a_h2s_zero_half, clk, rst, h2s_accepted, ##2 out_data.half_out == 16'd0)
endmodule
bind half_single_float_convert_top hsfc_checker u_hsfc_checker (.*);
`default_nettype wire
